### rtl/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter block.
// No dependencies; used by every module under rtl/ except psu_ram.
package psu_pkg;

  localparam int BYTE_W = 8;
  localparam int BPP_W  = 3;
  localparam int ROWB_W = 15;
  localparam int CFG_W  = 15;

  // Highest legal filter code; anything above is flagged as bad.
  localparam logic [BYTE_W-1:0] FILT_MAX = 8'd4;

  // Configuration register indexes.
  localparam logic REG_BPP  = 1'b0;
  localparam logic REG_ROWB = 1'b1;

  // PNG filter types.
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } psu_filt_t;

  // One accepted item as seen by the reconstruction stage.
  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    logic              is_filter;  // filter byte of a row
    logic              bad;        // filter byte with an illegal code
    logic              first;      // row above reads as zero
    logic              err;        // data byte of a row with an illegal code
    psu_filt_t         filt;       // filter of the current row
    logic              last;       // last data byte of the row
  } psu_item_t;

  // Status of the reconstruction stage.
  typedef struct packed {
    logic busy;        // stage register holds an item
    logic has_result;  // that item produces a result
    logic advance;     // the item moves on this cycle
  } psu_stage_t;

endpackage

### rtl/psu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/psu_rowtrack.sv
// Row position tracking: classifies each input byte as filter or data byte,
// computes its column and the row flags. Depends on psu_pkg.
module psu_rowtrack import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES = 16384
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [BYTE_W-1:0]                raw_byte,
  input  logic                             pass_start,
  input  logic [ROWB_W-1:0]                row_bytes,
  output psu_item_t                        item,
  output logic [$clog2(MAX_ROW_BYTES)-1:0] idx
);

  localparam int PW = $clog2(MAX_ROW_BYTES + 1);
  localparam int IW = $clog2(MAX_ROW_BYTES);
  localparam int CW = (PW > ROWB_W) ? PW : ROWB_W;

  logic [PW-1:0] byte_position;
  logic          first_row;
  logic          row_error;
  psu_filt_t     row_filter;

  logic [PW-1:0] pos;
  logic          fr;
  logic [CW-1:0] rb_ext;
  logic [CW-1:0] len_full;
  logic [PW-1:0] len;
  logic [PW-1:0] idx_full;
  logic          is_filter;
  logic          last;
  logic          bad;

  // A pass start abandons any partial row and opens a first row.
  assign pos = pass_start ? '0 : byte_position;
  assign fr  = pass_start | first_row;

  // Effective row length, clamped to 1..MAX_ROW_BYTES.
  assign rb_ext = CW'(row_bytes);
  always_comb begin
    priority if (rb_ext == '0) begin
      len_full = CW'(1);
    end else if (rb_ext > CW'(MAX_ROW_BYTES)) begin
      len_full = CW'(MAX_ROW_BYTES);
    end else begin
      len_full = rb_ext;
    end
  end
  assign len = len_full[PW-1:0];

  // Column of this data byte; a count that has reached the length ends the row.
  assign is_filter = (pos == '0);
  assign last      = !is_filter && (pos >= len);
  assign idx_full  = last ? (len - PW'(1)) : (pos - PW'(1));
  assign idx       = idx_full[IW-1:0];
  assign bad       = raw_byte > FILT_MAX;

  assign item.raw       = raw_byte;
  assign item.is_filter = is_filter;
  assign item.bad       = bad;
  assign item.first     = fr;
  assign item.err       = row_error;
  assign item.filt      = row_filter;
  assign item.last      = last;

  // Row state advances with every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      first_row     <= 1'b1;
      row_error     <= 1'b0;
      row_filter    <= FILT_NONE;
    end else if (accept) begin
      if (is_filter) begin
        byte_position <= PW'(1);
        first_row     <= fr;
        row_error     <= bad;
        row_filter    <= bad ? FILT_NONE : psu_filt_t'(raw_byte[2:0]);
      end else if (last) begin
        byte_position <= '0;
        first_row     <= 1'b0;
      end else begin
        byte_position <= pos + PW'(1);
        first_row     <= fr;
      end
    end
  end

endmodule

### rtl/psu_recon.sv
// Reconstruction stage: input register, filter arithmetic, result register.
// Depends on psu_pkg; the byte above comes from the row store's read port.
module psu_recon import psu_pkg::*; #(
  parameter int IW = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  psu_item_t         item_in,
  input  logic [IW-1:0]     idx_in,
  input  logic [BPP_W-1:0]  bytes_per_pixel,
  input  logic [BYTE_W-1:0] above,
  output logic              in_ready,
  output psu_stage_t        status,
  output logic              wr_en,
  output logic [IW-1:0]     wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic              out_bad
);

  psu_item_t     s1;
  logic          s1_valid;
  logic [IW-1:0] s1_idx;
  logic [31:0]   left_history;
  logic [31:0]   upleft_history;

  logic              has_result;
  logic              advance;
  logic [1:0]        sel;
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] c;
  logic [BYTE_W:0]   ab_sum;
  logic signed [9:0] d_bc;
  logic signed [9:0] d_ac;
  logic signed [9:0] d_p;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [BYTE_W-1:0] pred;
  logic [BYTE_W-1:0] val;

  // Stage handshake: a filter byte with a legal code produces nothing.
  assign has_result = s1.is_filter ? s1.bad : 1'b1;
  assign advance    = s1_valid && (!has_result || !out_valid || out_ready);
  assign in_ready   = !s1_valid || advance;

  assign status.busy       = s1_valid;
  assign status.has_result = s1_valid && has_result;
  assign status.advance    = advance;

  // Neighbor bytes: left and above-left one pixel back, above from the store.
  always_comb begin
    priority if (bytes_per_pixel == '0) begin
      sel = 2'd0;
    end else if (bytes_per_pixel > BPP_W'(4)) begin
      sel = 2'd3;
    end else begin
      sel = 2'(bytes_per_pixel - BPP_W'(1));
    end
  end
  assign a = left_history[8*sel +: 8];
  assign c = upleft_history[8*sel +: 8];
  assign b = s1.first ? '0 : above;

  // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
  assign ab_sum = {1'b0, a} + {1'b0, b};
  assign d_bc   = $signed({2'b00, b}) - $signed({2'b00, c});
  assign d_ac   = $signed({2'b00, a}) - $signed({2'b00, c});
  assign d_p    = d_bc + d_ac;
  assign pa     = d_bc[9] ? 10'(-d_bc) : 10'(d_bc);
  assign pb     = d_ac[9] ? 10'(-d_ac) : 10'(d_ac);
  assign pc     = d_p[9]  ? 10'(-d_p)  : 10'(d_p);

  // Predictor of the row's filter.
  always_comb begin
    unique case (s1.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[BYTE_W:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = '0;
    endcase
  end

  // Rows with an illegal code pass their data through unchanged.
  assign val = s1.err ? s1.raw : BYTE_W'(s1.raw + pred);

  // Reconstructed data bytes become the row above for the next row.
  assign wr_en   = advance && !s1.is_filter;
  assign wr_addr = s1_idx;
  assign wr_data = val;

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1     <= item_in;
      s1_idx <= idx_in;
    end
  end

  // Per-row pixel history, cleared by each filter byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_history   <= '0;
      upleft_history <= '0;
    end else if (advance) begin
      if (s1.is_filter) begin
        left_history   <= '0;
        upleft_history <= '0;
      end else begin
        left_history   <= {left_history[23:0], val};
        upleft_history <= {upleft_history[23:0], b};
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_byte <= s1.is_filter ? s1.raw : val;
      out_last <= !s1.is_filter && s1.last;
      out_bad  <= s1.is_filter || s1.err;
    end
  end

endmodule

### rtl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: config registers, row tracking,
// previous-row store and reconstruction stage. Depends on psu_pkg and all
// psu_* modules.
//
// Usage: decompressed scanline bytes enter on the s_ stream, one byte per
// item; s_tuser marks the first byte of an image or interlace pass. Each row
// is a filter byte followed by row_bytes data bytes. Reconstructed bytes
// leave on the m_ stream with m_tlast on the last byte of each row and
// m_tuser set for rows whose filter code is illegal (the filter byte itself
// then yields one item carrying the code). Legal filter bytes yield nothing.
// An accepted item sits in the stage register while the above byte is read
// from the row store; its result then goes into the result register and is
// shown on m_tvalid. Throughput is one item per cycle while the receiver
// keeps up; the limit is the single read and write port of the row store.
// When the receiver stalls, one result waits in the result register and
// one item in the stage register; s_tready then drops until the result is
// taken. Reset (rst, synchronous) empties both registers and restores
// bytes_per_pixel and row_bytes to 4 and expects a filter byte of a first
// row. The row store is not cleared; the first row of every pass reads the
// row above as zero. The user writes configuration only while idle, through
// cfg_we/cfg_index/cfg_data; the block itself does not enforce this.
module png_scanline_unfilter import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES = 16384
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] raw_byte
  input  logic              s_tuser,   // [0] pass_start
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast,
  output logic              m_tuser,   // [0] bad_filter
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int IW = $clog2(MAX_ROW_BYTES);

  logic [BPP_W-1:0]  bytes_per_pixel;
  logic [ROWB_W-1:0] row_bytes;
  logic              accept;
  psu_item_t         item;
  logic [IW-1:0]     idx;
  logic [BYTE_W-1:0] above;
  psu_stage_t        status;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(4);
      row_bytes       <= ROWB_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BPP:  bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_ROWB: row_bytes       <= cfg_data[ROWB_W-1:0];
        default:  ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  psu_rowtrack #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_rowtrack (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .raw_byte   (s_tdata),
    .pass_start (s_tuser),
    .row_bytes  (row_bytes),
    .item       (item),
    .idx        (idx)
  );

  // Previous-row store: read as an item enters, written as it leaves.
  psu_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_ROW_BYTES)
  ) u_above_row (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (idx),
    .rdata (above)
  );

  psu_recon #(
    .IW(IW)
  ) u_recon (
    .clk             (clk),
    .rst             (rst),
    .load            (accept),
    .item_in         (item),
    .idx_in          (idx),
    .bytes_per_pixel (bytes_per_pixel),
    .above           (above),
    .in_ready        (s_tready),
    .status          (status),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_byte        (m_tdata),
    .out_last        (m_tlast),
    .out_bad         (m_tuser)
  );

  // After reset the block is empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not empty after reset");

  // A result blocked by a full, stalled output must hold back the input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (status.has_result && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while stage is blocked");

  // Every row store write comes with a result in the next cycle.
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> m_tvalid)
    else $error("row store written without a result");

endmodule

### test/psu_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the PNG scanline unfilter: watches the input, output and config ports,
// recomputes every reconstructed byte and compares it with what the block emits.
// Depends on psu_pkg for widths, register indexes and filter codes.
module psu_checker import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] raw_byte
  input  logic             s_tuser,   // [0] pass_start
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [7:0]       m_tdata,   // [7:0] out_byte
  input  logic             m_tlast,
  input  logic             m_tuser,   // [0] bad_filter
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               error_count,
  output int               pending
);

  // One reconstructed byte as it should leave the block.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              bad;
  } recon_t;

  recon_t expected_bytes[$];

  // Shadow of the block's row state and registers.
  logic [BYTE_W-1:0] prev_row [MAX_ROW_BYTES];
  logic [31:0]       left_bytes;
  logic [31:0]       upleft_bytes;
  psu_filt_t         row_filt;
  int                row_pos;
  logic              in_first_row;
  logic              row_bad;
  logic [BPP_W-1:0]  bpp_reg;
  logic [ROWB_W-1:0] rowb_reg;

  // Paeth predictor: pick whichever neighbor is closest to a + b - c.
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int ia, ib, ic, p, pa, pb, pc;
    ia = int'(a);
    ib = int'(b);
    ic = int'(c);
    p = ia + ib - ic;
    pa = (p > ia) ? p - ia : ia - p;
    pb = (p > ib) ? p - ib : ib - p;
    pc = (p > ic) ? p - ic : ic - p;
    if (pa <= pb && pa <= pc) return a;
    else if (pb <= pc) return b;
    else return c;
  endfunction

  // Advance the shadow state by one accepted byte and queue its result, if any.
  task automatic unfilter_byte(input logic [7:0] raw, input logic ps);
    int len, idx, shift, bpp;
    logic [7:0] a, b, c, val;
    logic last;
    recon_t r;
    if (ps) begin
      in_first_row = 1'b1;
      row_pos = 0;
    end
    if (row_pos == 0) begin
      // Filter byte: only an illegal code yields a result.
      left_bytes = '0;
      upleft_bytes = '0;
      row_pos = 1;
      if (raw > FILT_MAX) begin
        row_bad = 1'b1;
        row_filt = FILT_NONE;
        r.value = raw;
        r.last = 1'b0;
        r.bad = 1'b1;
        expected_bytes.push_back(r);
      end else begin
        row_bad = 1'b0;
        row_filt = psu_filt_t'(raw[2:0]);
      end
    end else begin
      len = (rowb_reg == 0) ? 1 : ((int'(rowb_reg) > MAX_ROW_BYTES) ? MAX_ROW_BYTES
                                                                    : int'(rowb_reg));
      // A shortened row ends on the byte that reaches the new length.
      idx = row_pos - 1;
      if (idx >= len) idx = len - 1;
      last = (idx + 1 >= len);
      bpp = (bpp_reg == 0) ? 1 : ((bpp_reg > 4) ? 4 : int'(bpp_reg));
      shift = 8 * (bpp - 1);
      a = 8'(left_bytes >> shift);
      c = 8'(upleft_bytes >> shift);
      b = in_first_row ? 8'h00 : prev_row[idx];
      if (row_bad) begin
        val = raw;
      end else begin
        case (row_filt)
          FILT_SUB:   val = raw + a;
          FILT_UP:    val = raw + b;
          FILT_AVG:   val = raw + 8'((9'(a) + 9'(b)) >> 1);
          FILT_PAETH: val = raw + paeth_pick(a, b, c);
          default:    val = raw;
        endcase
      end
      prev_row[idx] = val;
      left_bytes = {left_bytes[23:0], val};
      upleft_bytes = {upleft_bytes[23:0], b};
      r.value = val;
      r.last = last;
      r.bad = row_bad;
      expected_bytes.push_back(r);
      if (last) begin
        row_pos = 0;
        in_first_row = 1'b0;
      end else begin
        row_pos = idx + 2;
      end
    end
  endtask

  // Outputs are checked before the input of the same edge is predicted, so a
  // stray result can never be matched against a fresh expectation.
  always @(posedge clk) begin
    recon_t e;
    if (rst) begin
      expected_bytes.delete();
      error_count = 0;
      left_bytes = '0;
      upleft_bytes = '0;
      row_filt = FILT_NONE;
      row_pos = 0;
      in_first_row = 1'b1;
      row_bad = 1'b0;
      bpp_reg = 3'd4;
      rowb_reg = 15'd4;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output item: out_byte %0h row_last %0b bad_filter %0b",
                 m_tdata, m_tlast, m_tuser);
          error_count++;
        end else begin
          e = expected_bytes.pop_front();
          if (m_tdata !== e.value) begin
            $error("out_byte mismatch: expected %0h, got %0h", e.value, m_tdata);
            error_count++;
          end
          if (m_tlast !== e.last) begin
            $error("row_last mismatch: expected %0b, got %0b", e.last, m_tlast);
            error_count++;
          end
          if (m_tuser !== e.bad) begin
            $error("bad_filter mismatch: expected %0b, got %0b", e.bad, m_tuser);
            error_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_BPP) bpp_reg = cfg_data[BPP_W-1:0];
        else rowb_reg = cfg_data[ROWB_W-1:0];
      end
      if (s_tvalid && s_tready) unfilter_byte(s_tdata, s_tuser);
    end
    pending = expected_bytes.size();
  end

endmodule

### test/tb_png_scanline_unfilter.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the PNG scanline unfilter: directed rows and random
// images under random stalls. Depends on psu_pkg, psu_checker and the RTL.
module tb_png_scanline_unfilter;
  import psu_pkg::*;

  localparam int ROW_MAX = 16384;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;   // [7:0] raw_byte
  logic             s_tuser = 1'b0; // [0] pass_start
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;        // [7:0] out_byte
  logic             m_tlast;
  logic             m_tuser;        // [0] bad_filter
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_BPP;
  logic [CFG_W-1:0] cfg_data = '0;

  int error_count;
  int pending;
  int sent = 0;
  int cur_len = 4;
  bit idling_on = 1'b1;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  png_scanline_unfilter #(.MAX_ROW_BYTES(ROW_MAX)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  psu_checker #(.MAX_ROW_BYTES(ROW_MAX)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .pending(pending)
  );

  // Receiver: short random stalls, plus one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Random data byte, leaning a little toward the extremes.
  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // Offer one item, with an optional gap in front, and wait until it is taken.
  task automatic send_item(input logic [7:0] raw, input logic ps);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= raw;
    s_tuser <= ps;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_row(input logic [7:0] code, input logic ps, input logic [7:0] d0,
                          input logic [7:0] d1);
    send_item(code, ps);
    send_item(d0, 1'b0);
    send_item(d1, 1'b0);
  endtask

  // One image or pass of random rows; now and then a row is cut short by a new pass.
  task automatic send_image(input int rows);
    int r, k;
    bit fresh;
    logic [7:0] code;
    fresh = 1'b1;
    for (r = 0; r < rows; r++) begin
      code = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(5, 255))
                                          : 8'($urandom_range(0, 4));
      send_item(code, fresh);
      fresh = 1'b0;
      for (k = 0; k < cur_len; k++) begin
        if ($urandom_range(0, 99) == 0) begin
          fresh = 1'b1;
          break;
        end
        send_item(rand_byte(), 1'b0);
      end
    end
  endtask

  // Pick a fresh configuration and send one image with it.
  task automatic random_phase(input bit long_hold);
    logic [BPP_W-1:0] bpp;
    logic [ROWB_W-1:0] rowb;
    int sel;
    wait_idle();
    bpp = 3'($urandom_range(0, 7));
    sel = $urandom_range(0, 19);
    if (sel == 0) rowb = '0;
    else if (sel < 3) rowb = 15'($urandom_range(17, 64));
    else rowb = 15'($urandom_range(1, 16));
    // Upper data bits are don't-care for the pixel size register.
    write_reg(REG_BPP, (15'($urandom) & 15'h7FF8) | 15'(bpp));
    write_reg(REG_ROWB, rowb);
    cur_len = (rowb == 0) ? 1 : int'(rowb);
    if (long_hold) hold_req = 1'b1;
    send_image($urandom_range(1, 8));
  endtask

  initial begin
    int base, phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: every filter, byte wraparound, illegal codes.
    write_reg(REG_BPP, 15'd1);
    write_reg(REG_ROWB, 15'd2);
    send_row(FILT_NONE, 1'b1, 8'h00, 8'hFF);
    send_row(FILT_SUB, 1'b0, 8'hFF, 8'h01);
    send_row(FILT_UP, 1'b0, 8'h80, 8'h7F);
    send_row(FILT_AVG, 1'b0, 8'hFF, 8'hFF);
    send_row(FILT_PAETH, 1'b0, 8'h01, 8'hFE);
    send_row(8'hFF, 1'b0, 8'h12, 8'h34);
    send_row(8'h05, 1'b0, 8'h00, 8'hFF);
    // A partial row abandoned by a new pass.
    send_item(FILT_PAETH, 1'b0);
    send_item(8'h55, 1'b0);
    send_row(FILT_UP, 1'b1, 8'hAA, 8'h55);
    // Row length shrinks while a row is under way: the next byte ends it.
    send_item(FILT_SUB, 1'b0);
    send_item(8'h10, 1'b0);
    wait_idle();
    write_reg(REG_ROWB, 15'd1);
    send_item(8'h20, 1'b0);
    send_item(FILT_UP, 1'b0);
    send_item(8'h01, 1'b0);

    // Random images under random stalls; one phase sees a long receiver hold.
    base = sent;
    phase = 0;
    while (sent - base < 1500) begin
      random_phase(phase == 3);
      phase++;
    end

    // Closing stretch at full rate on both sides, with one configuration.
    idling_on = 1'b0;
    base = sent;
    random_phase(1'b0);
    while (sent - base < 300) send_image($urandom_range(1, 8));

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #60_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
